// ===== design/tdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types, constants and controller/datapath interface structs for the
// trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int NUMBER_BITS = 32;
   localparam int STEP_BITS   = $clog2(NUMBER_BITS);

   typedef logic [NUMBER_BITS-1:0] value_type;
   typedef logic [STEP_BITS-1:0]   step_type;

   localparam value_type VALUE_ONE   = value_type'(1);
   localparam value_type VALUE_TWO   = value_type'(2);
   localparam value_type VALUE_THREE = value_type'(3);
   localparam step_type  LAST_STEP   = step_type'(NUMBER_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIVIDE,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic div_advance;
      logic set_prime;
      logic set_composite;
      logic out_load;
   } command_type;

   typedef struct packed {
      logic trivial_prime;
      logic trivial_composite;
      logic div_last;
      logic quot_lt_div;
      logic rem_zero;
   } status_type;

endpackage

// ===== design/tdpt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate and divisor registers, a restoring divider that retires one
// quotient bit per cycle, the verdict bit and the result register.
// ----------------------------------------------------------------------------
module tdpt_datapath (
   input  logic                   clock,
   input  logic [31:0]            req_candidate,
   input  tdpt_pkg::command_type  cmd,
   output tdpt_pkg::status_type   status,
   output logic                   rsp_is_prime
);

   logic [tdpt_pkg::NUMBER_BITS+31:0] cand_ext;
   tdpt_pkg::value_type               value;

   tdpt_pkg::value_type n_ff,    n_in;
   logic                neg_ff,  neg_in;
   tdpt_pkg::value_type div_ff,  div_in;
   tdpt_pkg::value_type rem_ff,  rem_in;
   tdpt_pkg::value_type quot_ff, quot_in;
   tdpt_pkg::step_type  cnt_ff,  cnt_in;
   logic                prime_ff, prime_in;
   logic                out_ff,   out_in;

   logic [tdpt_pkg::NUMBER_BITS:0] trial;
   logic [tdpt_pkg::NUMBER_BITS:0] trial_diff;
   logic                           fits;

   assign cand_ext = {{tdpt_pkg::NUMBER_BITS{1'b0}}, req_candidate};
   assign value    = cand_ext[tdpt_pkg::NUMBER_BITS-1:0];

   assign trial      = {rem_ff, quot_ff[tdpt_pkg::NUMBER_BITS-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign fits       = trial >= {1'b0, div_ff};

   always_comb begin
      n_in     = n_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      prime_in = prime_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         n_in   = value;
         neg_in = value[tdpt_pkg::NUMBER_BITS-1];
         div_in = tdpt_pkg::VALUE_THREE;
      end
      if (cmd.div_advance) begin
         div_in = div_ff + tdpt_pkg::VALUE_TWO;
      end
      if (cmd.div_init) begin
         rem_in  = '0;
         quot_in = n_ff;
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         rem_in  = fits ? trial_diff[tdpt_pkg::NUMBER_BITS-1:0]
                        : trial[tdpt_pkg::NUMBER_BITS-1:0];
         quot_in = {quot_ff[tdpt_pkg::NUMBER_BITS-2:0], fits};
         cnt_in  = cnt_ff + tdpt_pkg::step_type'(1);
      end
      if (cmd.set_prime) begin
         prime_in = 1'b1;
      end else if (cmd.set_composite) begin
         prime_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_in = prime_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      neg_ff   <= neg_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
      out_ff   <= out_in;
   end

   always_comb begin
      status.trivial_prime     = !neg_ff && (n_ff == tdpt_pkg::VALUE_TWO);
      status.trivial_composite = neg_ff || (n_ff <= tdpt_pkg::VALUE_ONE)
                                 || (!n_ff[0] && (n_ff != tdpt_pkg::VALUE_TWO));
      status.div_last          = cnt_ff == tdpt_pkg::LAST_STEP;
      status.quot_lt_div       = quot_ff < div_ff;
      status.rem_zero          = rem_ff == '0;
   end

   assign rsp_is_prime = out_ff;

endmodule

// ===== design/tdpt_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_controller
// Sequencer for one request at a time: classify, divide per odd divisor,
// decide, then hand the verdict to the result register.
// ----------------------------------------------------------------------------
module tdpt_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tdpt_pkg::status_type  status,
   output tdpt_pkg::command_type cmd
);

   tdpt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = tdpt_pkg::ST_CLASSIFY;
            end
         end
         tdpt_pkg::ST_CLASSIFY: begin
            if (status.trivial_prime) begin
               cmd.set_prime = 1'b1;
               state_in      = tdpt_pkg::ST_FINISH;
            end else if (status.trivial_composite) begin
               cmd.set_composite = 1'b1;
               state_in          = tdpt_pkg::ST_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = tdpt_pkg::ST_DIVIDE;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = tdpt_pkg::ST_DECIDE;
            end
         end
         tdpt_pkg::ST_DECIDE: begin
            if (status.quot_lt_div) begin
               cmd.set_prime = 1'b1;
               state_in      = tdpt_pkg::ST_FINISH;
            end else if (status.rem_zero) begin
               cmd.set_composite = 1'b1;
               state_in          = tdpt_pkg::ST_FINISH;
            end else begin
               cmd.div_advance = 1'b1;
               cmd.div_init    = 1'b1;
               state_in        = tdpt_pkg::ST_DIVIDE;
            end
         end
         tdpt_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/trial_division_prime_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Reports whether a signed integer is prime by trial division with odd
// divisors from three upward.
//
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_candidate [31:0], signed
// rsp_      out        rsp_valid / rsp_ready  rsp_is_prime
//
// Negative, zero, one, two and even requests are settled in the classify
// step without any division. Otherwise each odd divisor costs one pass of
// the one-bit-per-cycle restoring divider and a decide step. The next
// request is taken once the result register has loaded.
// Reset clears the sequencer and the result valid flag.
// A finished result waits in its own register; a new request is taken while
// it is held, and only the next verdict waits for rsp_ready.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_prime
);

   tdpt_pkg::command_type cmd;
   tdpt_pkg::status_type  status;

   tdpt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdpt_datapath u_datapath (
      .clock         (clock),
      .req_candidate (req_candidate),
      .cmd           (cmd),
      .status        (status),
      .rsp_is_prime  (rsp_is_prime)
   );

endmodule

// ===== design/tdpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks on the prime test, bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_prime
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_prime))
      else $error("stalled result dropped or changed");

   // busy after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no verdict in the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early after request");

   // reset clears the result valid flag
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the block is ready for a new request whenever a result first rises
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result delivered while request pending");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_is_prime  (rsp_is_prime)
);
